/* rtl/core/pwlr_pkg.sv */
// shared types, constants and codes for the pooling-window linear relaxation block
// no dependencies
package pwlr_pkg;

	localparam int WINDOW_SIZE = 4;
	localparam int FRAC_BITS   = 16;
	localparam int INDEX_BITS  = 20;
	localparam int BOUND_W     = 32;
	localparam int COEF_W      = FRAC_BITS + 1;
	localparam int CNT_W       = 3;
	localparam int DIV_W       = 34;
	localparam int STEP_W      = 6;

	localparam logic [COEF_W-1:0] ONE_Q      = COEF_W'(1) << FRAC_BITS;
	localparam logic [COEF_W-1:0] COEF_HALF  = ONE_Q >> 1;
	localparam logic [COEF_W-1:0] COEF_QUART = ONE_Q >> 2;
	localparam logic [COEF_W-1:0] COEF_THIRD = COEF_W'((1 << FRAC_BITS) / 3);

	localparam logic [2:0] CASE_FLAT  = 3'd0;
	localparam logic [2:0] CASE_ONE   = 3'd1;
	localparam logic [2:0] CASE_TWO   = 3'd2;
	localparam logic [2:0] CASE_THREE = 3'd3;
	localparam logic [2:0] CASE_FOUR  = 3'd4;
	localparam logic [2:0] CASE_AVG   = 3'd5;
	localparam logic [2:0] CASE_SHORT = 3'd6;

	typedef struct packed {
		logic [INDEX_BITS-1:0]     element_index;
		logic signed [BOUND_W-1:0] lower_bound;
		logic signed [BOUND_W-1:0] upper_bound;
		logic                      last_element;
	} element_t;

	typedef struct packed {
		logic [2:0]                case_code;
		logic [INDEX_BITS-1:0]     lower_index;
		logic [COEF_W-1:0]         lower_coeff;
		logic [INDEX_BITS-1:0]     upper_index_first;
		logic [COEF_W-1:0]         upper_coeff_first;
		logic [INDEX_BITS-1:0]     upper_index_second;
		logic [COEF_W-1:0]         upper_coeff_second;
		logic signed [BOUND_W-1:0] upper_const;
		logic signed [BOUND_W-1:0] bound_low;
		logic signed [BOUND_W-1:0] bound_high;
		logic [CNT_W-1:0]          element_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL_A,
		ST_MUL_B,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		JOB_C1,
		JOB_C2,
		JOB_LO,
		JOB_HI
	} job_t;

	typedef enum logic [1:0] {
		COEF_ZERO,
		COEF_ONE,
		COEF_DIV
	} coef_kind_t;

	typedef struct packed {
		logic accept;
		logic classify;
		logic div_start;
		logic div_capture;
		job_t div_job;
		logic mul_a;
		logic mul_b;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic avg_mode;
		logic short_window;
		logic need_c1;
		logic need_c2;
		logic div_done;
	} dp_status_t;

endpackage

/* rtl/core/pwlr_div.sv */
// serial restoring divider, one quotient bit per cycle
// depends on pwlr_pkg
module pwlr_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pwlr_pkg::DIV_W-1:0]   rem_init,
	input  logic [pwlr_pkg::DIV_W-1:0]   dividend,
	input  logic [pwlr_pkg::DIV_W-1:0]   divisor,
	input  logic [pwlr_pkg::STEP_W-1:0]  steps,
	output logic                         done,
	output logic [pwlr_pkg::DIV_W-1:0]   quot
);
	logic [pwlr_pkg::DIV_W-1:0]  rem_q, dvd_q, den_q, quot_q;
	logic [pwlr_pkg::STEP_W-1:0] cnt_q;
	logic                        run_q, done_q;
	logic [pwlr_pkg::DIV_W:0]    trial;
	logic                        ge;

	assign trial = {rem_q, dvd_q[pwlr_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pwlr_pkg::STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			dvd_q  <= dividend;
			den_q  <= divisor;
			quot_q <= '0;
		end else if (run_q) begin
			// remainder stays below the divisor, so it fits back in DIV_W bits
			rem_q  <= ge ? pwlr_pkg::DIV_W'(trial - {1'b0, den_q})
			             : trial[pwlr_pkg::DIV_W-1:0];
			dvd_q  <= {dvd_q[pwlr_pkg::DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[pwlr_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule

/* rtl/core/pwlr_dp.sv */
// datapath: window statistics, case selection, coefficients, constant and result register
// depends on pwlr_pkg and pwlr_div
module pwlr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pwlr_pkg::element_t    element,
	input  logic                  cfg_valid,
	input  logic                  cfg_data,
	input  pwlr_pkg::ctrl_cmd_t   cmd,
	output pwlr_pkg::dp_status_t  status,
	output logic                  result_valid,
	output pwlr_pkg::result_t     result
);
	localparam int DW = pwlr_pkg::DIV_W;
	localparam int BW = pwlr_pkg::BOUND_W;
	localparam int PW = pwlr_pkg::COEF_W + 1 + BW;
	localparam int AW = DW + 2;

	typedef struct packed {
		logic [pwlr_pkg::INDEX_BITS-1:0] idx;
		logic signed [BW-1:0]            lo;
		logic signed [BW-1:0]            hi;
	} slot_t;

	logic                                pool_mode_q;
	logic [pwlr_pkg::CNT_W-1:0]          fill_q, count_q;
	slot_t                               t1_q, t2_q, t3_q, fresh;
	logic signed [BW-1:0]                lmax_q;
	logic signed [BW:0]                  mid_sum_q, mid_new;
	logic [pwlr_pkg::INDEX_BITS-1:0]     mid_idx_q;
	logic signed [DW-1:0]                sum_lo_q, sum_hi_q;
	logic                                keep, first;

	logic [2:0]                          case_q, case_c;
	logic signed [DW-1:0]                u, u1l, u2, u2l, u3, lv;
	logic signed [DW-1:0]                num1_c, den1_c, num2_c, den2_c;
	logic signed [DW-1:0]                num1_q, den1_q, num2_q, den2_q;
	pwlr_pkg::coef_kind_t                kind1_c, kind2_c;
	logic signed [BW-1:0]                kbase_q;
	logic [pwlr_pkg::COEF_W-1:0]         c1_q, c2_q, avg_coef;
	logic signed [PW-1:0]                prod_q;
	logic signed [AW-1:0]                acc_q, k_full;
	logic signed [BW-1:0]                k_sat, lo_q, hi_q, avg_res;
	pwlr_pkg::result_t                   res_d;

	logic                                div_done;
	logic [DW-1:0]                       quot, rem_init, dividend, divisor;
	logic [pwlr_pkg::STEP_W-1:0]         steps;
	logic [DW-1:0]                       mag_lo, mag_hi, n_minus1;
	logic                                neg_sel;

	function automatic pwlr_pkg::coef_kind_t ratio_kind(
		input logic signed [DW-1:0] num,
		input logic signed [DW-1:0] den
	);
		pwlr_pkg::coef_kind_t k;
		if (den <= 0)
			k = pwlr_pkg::COEF_ONE;
		else if (num <= 0)
			k = pwlr_pkg::COEF_ZERO;
		else if (num >= den)
			k = pwlr_pkg::COEF_ONE;
		else
			k = pwlr_pkg::COEF_DIV;
		return k;
	endfunction

	function automatic logic [pwlr_pkg::COEF_W-1:0] fixed_coef(
		input pwlr_pkg::coef_kind_t k
	);
		return (k == pwlr_pkg::COEF_ONE) ? pwlr_pkg::ONE_Q : '0;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pool_mode_q <= 1'b1;
		else if (cfg_valid)
			pool_mode_q <= cfg_data;
	end

	// window fill and element count
	assign keep  = fill_q < pwlr_pkg::CNT_W'(pwlr_pkg::WINDOW_SIZE);
	assign first = fill_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			if (element.last_element) begin
				fill_q  <= '0;
				count_q <= keep ? fill_q + 1'b1 : fill_q;
			end else if (keep) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// running statistics: stable insertion of the top three uppers, ties stay behind
	assign fresh   = '{idx: element.element_index, lo: element.lower_bound,
	                   hi: element.upper_bound};
	assign mid_new = (BW+1)'(element.lower_bound) + (BW+1)'(element.upper_bound);

	always_ff @(posedge clk) begin
		if (cmd.accept && keep) begin
			if (first || element.upper_bound > t1_q.hi) begin
				t3_q <= t2_q;
				t2_q <= t1_q;
				t1_q <= fresh;
			end else if (fill_q == 3'd1 || element.upper_bound > t2_q.hi) begin
				t3_q <= t2_q;
				t2_q <= fresh;
			end else if (fill_q == 3'd2 || element.upper_bound > t3_q.hi) begin
				t3_q <= fresh;
			end
			if (first || element.lower_bound > lmax_q)
				lmax_q <= element.lower_bound;
			if (first || mid_new > mid_sum_q) begin
				mid_sum_q <= mid_new;
				mid_idx_q <= element.element_index;
			end
			sum_lo_q <= (first ? '0 : sum_lo_q) + DW'(element.lower_bound);
			sum_hi_q <= (first ? '0 : sum_hi_q) + DW'(element.upper_bound);
		end
	end

	// relaxation case selection
	assign u   = DW'(t1_q.hi);
	assign u1l = DW'(t1_q.lo);
	assign u2  = DW'(t2_q.hi);
	assign u2l = DW'(t2_q.lo);
	assign u3  = DW'(t3_q.hi);
	assign lv  = DW'(lmax_q);

	always_comb begin
		if (lv >= u)
			case_c = pwlr_pkg::CASE_FLAT;
		else if (lv >= u2 && u1l >= lv)
			case_c = pwlr_pkg::CASE_ONE;
		else if (lv >= u3 && lv < u2 && u1l >= lv)
			case_c = pwlr_pkg::CASE_TWO;
		else if (lv >= u3 && lv < u2 && u2l >= lv && u1l < lv)
			case_c = pwlr_pkg::CASE_THREE;
		else
			case_c = pwlr_pkg::CASE_FOUR;

		num1_c  = (case_c == pwlr_pkg::CASE_THREE) ? u - lv : u - u3;
		den1_c  = u - u1l;
		num2_c  = (case_c == pwlr_pkg::CASE_TWO) ? u2 - lv : u2 - u3;
		den2_c  = u2 - u2l;
		kind1_c = pwlr_pkg::COEF_ZERO;
		kind2_c = pwlr_pkg::COEF_ZERO;
		unique case (case_c)
			pwlr_pkg::CASE_ONE: begin
				kind1_c = pwlr_pkg::COEF_ONE;
			end
			pwlr_pkg::CASE_TWO: begin
				kind1_c = pwlr_pkg::COEF_ONE;
				kind2_c = ratio_kind(num2_c, den2_c);
			end
			pwlr_pkg::CASE_THREE: begin
				kind1_c = ratio_kind(num1_c, den1_c);
				kind2_c = pwlr_pkg::COEF_ONE;
			end
			pwlr_pkg::CASE_FOUR: begin
				kind1_c = ratio_kind(num1_c, den1_c);
				kind2_c = ratio_kind(num2_c, den2_c);
			end
			default: begin
				kind1_c = pwlr_pkg::COEF_ZERO;
				kind2_c = pwlr_pkg::COEF_ZERO;
			end
		endcase
	end

	assign status.avg_mode     = !pool_mode_q;
	assign status.short_window = count_q != pwlr_pkg::CNT_W'(pwlr_pkg::WINDOW_SIZE);
	assign status.need_c1      = kind1_c == pwlr_pkg::COEF_DIV;
	assign status.need_c2      = kind2_c == pwlr_pkg::COEF_DIV;
	assign status.div_done     = div_done;

	// divider operands
	assign n_minus1 = DW'(count_q) - 1'b1;
	assign mag_lo   = sum_lo_q[DW-1] ? DW'(-sum_lo_q) + n_minus1 : DW'(sum_lo_q);
	assign mag_hi   = sum_hi_q[DW-1] ? DW'(-sum_hi_q) + n_minus1 : DW'(sum_hi_q);

	always_comb begin
		unique case (cmd.div_job)
			pwlr_pkg::JOB_C1: begin
				rem_init = DW'(num1_q);
				dividend = '0;
				divisor  = DW'(den1_q);
				steps    = pwlr_pkg::STEP_W'(pwlr_pkg::FRAC_BITS);
				neg_sel  = 1'b0;
			end
			pwlr_pkg::JOB_C2: begin
				rem_init = DW'(num2_q);
				dividend = '0;
				divisor  = DW'(den2_q);
				steps    = pwlr_pkg::STEP_W'(pwlr_pkg::FRAC_BITS);
				neg_sel  = 1'b0;
			end
			pwlr_pkg::JOB_LO: begin
				rem_init = '0;
				dividend = mag_lo;
				divisor  = DW'(count_q);
				steps    = pwlr_pkg::STEP_W'(DW);
				neg_sel  = sum_lo_q[DW-1];
			end
			default: begin
				rem_init = '0;
				dividend = mag_hi;
				divisor  = DW'(count_q);
				steps    = pwlr_pkg::STEP_W'(DW);
				neg_sel  = sum_hi_q[DW-1];
			end
		endcase
	end

	pwlr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem_init (rem_init),
		.dividend (dividend),
		.divisor  (divisor),
		.steps    (steps),
		.done     (div_done),
		.quot     (quot)
	);

	// floor of a negative mean is the negated ceiling of the magnitude
	assign avg_res = neg_sel ? BW'(-quot) : BW'(quot);

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			case_q  <= case_c;
			num1_q  <= num1_c;
			den1_q  <= den1_c;
			num2_q  <= num2_c;
			den2_q  <= den2_c;
			c1_q    <= fixed_coef(kind1_c);
			c2_q    <= fixed_coef(kind2_c);
			kbase_q <= (case_c == pwlr_pkg::CASE_FOUR) ? t3_q.hi : lmax_q;
		end
		if (cmd.div_capture) begin
			unique case (cmd.div_job)
				pwlr_pkg::JOB_C1: c1_q <= quot[pwlr_pkg::COEF_W-1:0];
				pwlr_pkg::JOB_C2: c2_q <= quot[pwlr_pkg::COEF_W-1:0];
				pwlr_pkg::JOB_LO: lo_q <= avg_res;
				default:          hi_q <= avg_res;
			endcase
		end
		// constant = base - floor(c1*u1l) - floor(c2*u2l)
		if (cmd.mul_a)
			prod_q <= $signed({1'b0, c1_q}) * t1_q.lo;
		if (cmd.mul_b) begin
			acc_q  <= AW'(kbase_q) - AW'($signed(prod_q[PW-1:pwlr_pkg::FRAC_BITS]));
			prod_q <= $signed({1'b0, c2_q}) * t2_q.lo;
		end
	end

	assign k_full = acc_q - AW'($signed(prod_q[PW-1:pwlr_pkg::FRAC_BITS]));
	always_comb begin
		if (k_full > AW'(32'sh7FFF_FFFF))
			k_sat = 32'sh7FFF_FFFF;
		else if (k_full < -AW'(33'sh0_8000_0000))
			k_sat = 32'sh8000_0000;
		else
			k_sat = k_full[BW-1:0];
	end

	always_comb begin
		unique case (count_q)
			3'd2:    avg_coef = pwlr_pkg::COEF_HALF;
			3'd3:    avg_coef = pwlr_pkg::COEF_THIRD;
			3'd4:    avg_coef = pwlr_pkg::COEF_QUART;
			default: avg_coef = pwlr_pkg::ONE_Q;
		endcase
	end

	// result fields for the window being closed
	always_comb begin
		res_d               = '0;
		res_d.element_count = count_q;
		if (!pool_mode_q) begin
			res_d.case_code         = pwlr_pkg::CASE_AVG;
			res_d.lower_coeff       = avg_coef;
			res_d.upper_coeff_first = avg_coef;
			res_d.bound_low         = lo_q;
			res_d.bound_high        = hi_q;
		end else if (status.short_window) begin
			res_d.case_code = pwlr_pkg::CASE_SHORT;
		end else begin
			res_d.case_code          = case_q;
			res_d.lower_index        = mid_idx_q;
			res_d.lower_coeff        = pwlr_pkg::ONE_Q;
			res_d.upper_index_first  = t1_q.idx;
			res_d.upper_coeff_first  = c1_q;
			res_d.upper_index_second = t2_q.idx;
			res_d.upper_coeff_second = c2_q;
			res_d.upper_const        = k_sat;
			res_d.bound_low          = lmax_q;
			res_d.bound_high         = t1_q.hi;
		end
	end

	// result register, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit)
			result <= res_d;
	end
endmodule

/* rtl/core/pwlr_ctrl.sv */
// controller: sequences accept, classify, divisions, products and result emission
// depends on pwlr_pkg
module pwlr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  last_element,
	input  pwlr_pkg::dp_status_t  status,
	output pwlr_pkg::ctrl_cmd_t   cmd,
	output logic                  busy
);
	pwlr_pkg::state_t state_q, state_d;
	pwlr_pkg::job_t   job_q, job_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pwlr_pkg::ST_IDLE;
			job_q   <= pwlr_pkg::JOB_C1;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		job_d       = job_q;
		cmd         = '0;
		cmd.div_job = job_q;
		busy        = 1'b1;
		unique case (state_q)
			pwlr_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					if (last_element)
						state_d = pwlr_pkg::ST_CLASSIFY;
				end
			end
			pwlr_pkg::ST_CLASSIFY: begin
				cmd.classify = 1'b1;
				priority if (status.avg_mode) begin
					job_d   = pwlr_pkg::JOB_LO;
					state_d = pwlr_pkg::ST_DIV_GO;
				end else if (status.short_window) begin
					state_d = pwlr_pkg::ST_EMIT;
				end else if (status.need_c1) begin
					job_d   = pwlr_pkg::JOB_C1;
					state_d = pwlr_pkg::ST_DIV_GO;
				end else if (status.need_c2) begin
					job_d   = pwlr_pkg::JOB_C2;
					state_d = pwlr_pkg::ST_DIV_GO;
				end else begin
					state_d = pwlr_pkg::ST_MUL_A;
				end
			end
			pwlr_pkg::ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = pwlr_pkg::ST_DIV_WAIT;
			end
			pwlr_pkg::ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					unique case (job_q)
						pwlr_pkg::JOB_C1: begin
							if (status.need_c2) begin
								job_d   = pwlr_pkg::JOB_C2;
								state_d = pwlr_pkg::ST_DIV_GO;
							end else begin
								state_d = pwlr_pkg::ST_MUL_A;
							end
						end
						pwlr_pkg::JOB_C2: state_d = pwlr_pkg::ST_MUL_A;
						pwlr_pkg::JOB_LO: begin
							job_d   = pwlr_pkg::JOB_HI;
							state_d = pwlr_pkg::ST_DIV_GO;
						end
						default: state_d = pwlr_pkg::ST_EMIT;
					endcase
				end
			end
			pwlr_pkg::ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				state_d   = pwlr_pkg::ST_MUL_B;
			end
			pwlr_pkg::ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = pwlr_pkg::ST_EMIT;
			end
			pwlr_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = pwlr_pkg::ST_IDLE;
			end
			default: state_d = pwlr_pkg::ST_IDLE;
		endcase
	end
endmodule

/* rtl/core/pool_window_linear_relaxation.sv */
// top level of the pooling-window linear relaxation block
// depends on pwlr_pkg, pwlr_ctrl, pwlr_dp
//
// Elements are taken one per cycle (start while busy is low) until the one with
// last_element set; the block is then busy while it closes the window: a short max
// window goes from classify to emission; max mode runs each coefficient that needs a
// division (at most two) through one shared serial divider, then ST_MUL_A, ST_MUL_B;
// average mode runs two 34-bit serial divisions by the count. result_valid is high for
// exactly one cycle with the result, which cannot be held off. The user must write
// pool_mode through cfg_valid/cfg_data only while no window is being closed; the
// block does not enforce it. cfg_ready is always high.
module pool_window_linear_relaxation (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  pwlr_pkg::element_t  element,
	output logic                result_valid,
	output pwlr_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data
);
	pwlr_pkg::ctrl_cmd_t  cmd;
	pwlr_pkg::dp_status_t status;

	assign cfg_ready = 1'b1;

	pwlr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_element (element.last_element),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy)
	);

	pwlr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.element      (element),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule

/* rtl/core/pwlr_chk.sv */
// port-level checker for the pooling-window linear relaxation block, bound to the top
// depends on pwlr_pkg and pool_window_linear_relaxation
module pwlr_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input pwlr_pkg::element_t  element,
	input logic                result_valid,
	input pwlr_pkg::result_t   result,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic                cfg_data
);
	// a closing transaction always makes the block busy
	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && element.last_element |=> busy)
		else $error("window close did not raise busy");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// the result comes exactly as busy drops
	a_fell_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("busy dropped without a result");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy && cfg_ready)
		else $error("result shown while busy");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.element_count != 3'd0 && result.element_count <= 3'd4
			&& result.case_code != 3'd7)
		else $error("result count or case out of range");
endmodule

bind pool_window_linear_relaxation pwlr_chk u_pwlr_chk (.*);
